// ===== design/stp_pkg.sv =====
// Shared types and constants for the semiprime trial-division core.
// No dependencies; imported by the core and the candidate generator.
package stp_pkg;

    // Widths of the result factor fields.
    localparam int SMALL_BITS = 17;
    localparam int LARGE_BITS = 31;

    // Trial divisor sequence: 2, 3, then 5, 7, 11, 13, ... (6k-1, 6k+1).
    localparam int FIRST_CAND  = 2;
    localparam int SECOND_CAND = 3;
    localparam int THIRD_CAND  = 5;
    localparam int SHORT_STEP  = 2;
    localparam int LONG_STEP   = 4;

    // Smallest value that can be semiprime.
    localparam int MIN_SEMIPRIME = 4;

    // Control from the sequencer to the candidate generator.
    typedef struct packed {
        logic load;
        logic advance;
    } stp_cand_ctrl_t;

endpackage

// ===== design/semiprime_trial_division_core.sv =====
// Semiprime test by trial division. Each trial divisor goes through the bit-serial divider,
// which produces one quotient bit per cycle. The result for a value below 4 appears in the
// cycle after acceptance; larger values run the two-phase divisor search.
// One transaction is worked at a time; busy is high from the cycle after acceptance until
// the result appears, and a value below 4 never raises it. The result strobe done lasts one
// cycle and cannot be stalled. Reset (rst_n low, asynchronous) returns the block to idle.
module semiprime_trial_division_core
    import stp_pkg::*;
#(
    parameter int VALUE_BITS = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [VALUE_BITS-1:0] value,
    output logic                  busy,
    output logic                  done,
    output logic                  semi_flag,
    output logic [SMALL_BITS-1:0] small_factor,
    output logic [LARGE_BITS-1:0] large_factor
);

    // Trial divisors never need to pass sqrt(2^VALUE_BITS) by more than one step,
    // so half the value width plus two guard bits holds them.
    localparam int DIV_W = (VALUE_BITS + 1) / 2 + 2;

    // The search runs in two phases over one rising divisor sequence.
    // Phase one divides the value itself and stops at its smallest divisor p
    // (necessarily prime), or proves the value prime once the quotient drops
    // below the divisor. Phase two divides the cofactor m = value / p from p
    // upward: m has no factor below p, so if no divisor d with d*d <= m turns
    // up, m is prime and the value is the semiprime p * m.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV_START,
        ST_DIV_WAIT
    } core_state_t;

    core_state_t            state_reg;
    logic                   phase_b_reg;
    logic [VALUE_BITS-1:0]  n_reg;
    logic [VALUE_BITS-1:0]  m_reg;
    logic [DIV_W-1:0]       p_reg;
    logic                   done_reg;
    logic                   semi_reg;
    logic [SMALL_BITS-1:0]  small_reg;
    logic [LARGE_BITS-1:0]  large_reg;

    stp_cand_ctrl_t         cand_ctrl;
    logic [DIV_W-1:0]       cand;
    logic                   div_start;
    logic [VALUE_BITS-1:0]  div_dividend;
    logic                   div_done;
    logic [VALUE_BITS-1:0]  div_quotient;
    logic                   div_rem_zero;
    logic                   accept;
    logic                   past_root;

    // Factor fields are the low bits of the found factors, zero-extended when
    // the value is narrow.
    logic [DIV_W+SMALL_BITS-1:0]      small_wide;
    logic [VALUE_BITS+LARGE_BITS-1:0] large_wide;

    assign accept       = start && (state_reg == ST_IDLE);
    assign div_start    = (state_reg == ST_DIV_START);
    assign div_dividend = phase_b_reg ? m_reg : n_reg;

    // floor(x / d) < d exactly when d * d > x, so the quotient bounds the search.
    assign past_root = div_quotient < {{(VALUE_BITS-DIV_W){1'b0}}, cand};

    assign small_wide = {{SMALL_BITS{1'b0}}, p_reg};
    assign large_wide = {{LARGE_BITS{1'b0}}, m_reg};

    always_comb
    begin
        cand_ctrl.load    = accept;
        cand_ctrl.advance = (state_reg == ST_DIV_WAIT) && div_done && !past_root
                            && !div_rem_zero;
    end

    stp_cand #(
        .DIV_W (DIV_W)
    ) u_cand (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (cand_ctrl),
        .cand  (cand)
    );

    stp_divider #(
        .VALUE_BITS (VALUE_BITS),
        .DIV_W      (DIV_W)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (cand),
        .done     (div_done),
        .quotient (div_quotient),
        .rem_zero (div_rem_zero)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            phase_b_reg <= 1'b0;
            n_reg       <= '0;
            m_reg       <= '0;
            p_reg       <= '0;
            done_reg    <= 1'b0;
            semi_reg    <= 1'b0;
            small_reg   <= '0;
            large_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        n_reg       <= value;
                        phase_b_reg <= 1'b0;
                        if (value < VALUE_BITS'(MIN_SEMIPRIME))
                        begin
                            // Values 0 to 3 are never semiprime.
                            done_reg  <= 1'b1;
                            semi_reg  <= 1'b0;
                            small_reg <= '0;
                            large_reg <= '0;
                        end
                        else
                        begin
                            state_reg <= ST_DIV_START;
                        end
                    end
                end
                ST_DIV_START:
                begin
                    state_reg <= ST_DIV_WAIT;
                end
                ST_DIV_WAIT:
                begin
                    if (div_done)
                    begin
                        if (past_root)
                        begin
                            // No divisor up to the square root: in phase one the
                            // value is prime, in phase two the cofactor is.
                            state_reg <= ST_IDLE;
                            done_reg  <= 1'b1;
                            semi_reg  <= phase_b_reg;
                            small_reg <= phase_b_reg ? small_wide[SMALL_BITS-1:0] : '0;
                            large_reg <= phase_b_reg ? large_wide[LARGE_BITS-1:0] : '0;
                        end
                        else if (div_rem_zero && !phase_b_reg)
                        begin
                            // Smallest prime factor found; test the cofactor,
                            // starting again at the same divisor.
                            p_reg       <= cand;
                            m_reg       <= div_quotient;
                            phase_b_reg <= 1'b1;
                            state_reg   <= ST_DIV_START;
                        end
                        else if (div_rem_zero)
                        begin
                            // The cofactor is composite: three or more prime factors.
                            state_reg <= ST_IDLE;
                            done_reg  <= 1'b1;
                            semi_reg  <= 1'b0;
                            small_reg <= '0;
                            large_reg <= '0;
                        end
                        else
                        begin
                            state_reg <= ST_DIV_START;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign busy         = (state_reg != ST_IDLE);
    assign done         = done_reg;
    assign semi_flag    = semi_reg;
    assign small_factor = small_reg;
    assign large_factor = large_reg;

`ifndef SYNTHESIS
    // A result is only presented once the search has gone back to idle.
    assert property (@(posedge clk) disable iff (!rst_n) done |-> !busy)
        else $error("result strobe while the search is still busy");

    // A non-semiprime result carries zero factors.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && !semi_flag) |-> (small_factor == '0) && (large_factor == '0))
        else $error("factors not cleared on a non-semiprime result");

    // A semiprime result always has a nonzero small factor.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && semi_flag) |-> (small_factor != '0))
        else $error("semiprime result with zero small factor");

    // The divider only reports completion while the sequencer waits for it.
    assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIV_WAIT))
        else $error("divider completion outside the wait state");
`endif

endmodule

// ===== design/stp_divider.sv =====
// Bit-serial restoring divider: one quotient bit per clock cycle.
// Depends on nothing but the clock and reset; used by the core sequencer.
module stp_divider #(
    parameter int VALUE_BITS = 32,
    parameter int DIV_W      = 18
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [VALUE_BITS-1:0] dividend,
    input  logic [DIV_W-1:0]      divisor,
    output logic                  done,
    output logic [VALUE_BITS-1:0] quotient,
    output logic                  rem_zero
);

    localparam int CNT_W = $clog2(VALUE_BITS);

    typedef enum logic {
        DIV_IDLE,
        DIV_RUN
    } div_state_t;

    div_state_t            state_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [VALUE_BITS-1:0] quo_reg;
    logic [DIV_W-1:0]      rem_reg;
    logic [DIV_W-1:0]      div_reg;
    logic                  done_reg;

    logic [DIV_W:0]        rem_shift;
    logic [DIV_W+1:0]      diff;
    logic                  fits;
    logic [DIV_W-1:0]      rem_next;
    logic [VALUE_BITS-1:0] quo_next;

    // Bring down the next dividend bit and try to subtract the divisor.
    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[VALUE_BITS-1]};
        diff      = {1'b0, rem_shift} - {2'b00, div_reg};
        fits      = ~diff[DIV_W+1];
        rem_next  = fits ? diff[DIV_W-1:0] : rem_shift[DIV_W-1:0];
        quo_next  = {quo_reg[VALUE_BITS-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DIV_IDLE;
            cnt_reg   <= '0;
            quo_reg   <= '0;
            rem_reg   <= '0;
            div_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                DIV_IDLE:
                begin
                    if (start)
                    begin
                        quo_reg   <= dividend;
                        rem_reg   <= '0;
                        div_reg   <= divisor;
                        cnt_reg   <= '0;
                        state_reg <= DIV_RUN;
                    end
                end
                DIV_RUN:
                begin
                    quo_reg <= quo_next;
                    rem_reg <= rem_next;
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(VALUE_BITS - 1))
                    begin
                        state_reg <= DIV_IDLE;
                        done_reg  <= 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= DIV_IDLE;
                end
            endcase
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;
    assign rem_zero = (rem_reg == '0);

endmodule

// ===== design/stp_cand.sv =====
// Trial divisor generator: 2, 3, then alternating steps of 2 and 4 from 5.
// Depends on stp_pkg for the sequence constants and the control struct.
module stp_cand
    import stp_pkg::*;
#(
    parameter int DIV_W = 18
) (
    input  logic           clk,
    input  logic           rst_n,
    input  stp_cand_ctrl_t ctrl,
    output logic [DIV_W-1:0] cand
);

    logic [DIV_W-1:0] cand_reg;
    logic [DIV_W-1:0] cand_next;
    logic             long_reg;
    logic             long_next;

    always_comb
    begin
        cand_next = cand_reg;
        long_next = long_reg;
        if (ctrl.load)
        begin
            cand_next = DIV_W'(FIRST_CAND);
            long_next = 1'b0;
        end
        else if (ctrl.advance)
        begin
            if (cand_reg == DIV_W'(FIRST_CAND))
            begin
                cand_next = DIV_W'(SECOND_CAND);
            end
            else if (cand_reg == DIV_W'(SECOND_CAND))
            begin
                cand_next = DIV_W'(THIRD_CAND);
                long_next = 1'b0;
            end
            else
            begin
                cand_next = cand_reg + (long_reg ? DIV_W'(LONG_STEP) : DIV_W'(SHORT_STEP));
                long_next = ~long_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cand_reg <= DIV_W'(FIRST_CAND);
            long_reg <= 1'b0;
        end
        else
        begin
            cand_reg <= cand_next;
            long_reg <= long_next;
        end
    end

    assign cand = cand_reg;

endmodule

// ===== tb/tb_semiprime_trial_division_core.sv =====
// Self-checking testbench for semiprime_trial_division_core.
// Depends on stp_pkg and the core RTL; it needs no other file and no arguments.
`timescale 1ns / 100ps

module tb_semiprime_trial_division_core
    import stp_pkg::*;
();

    localparam int VALUE_BITS = 32;
    localparam int CLK_PERIOD = 10;
    // Work per trial divisor, used to scale the watchdog limit and the final wait.
    localparam int CYCLES_PER_DIVISOR = VALUE_BITS + 2;
    localparam int FIRST_REPORTS = 10;

    // One expected result, tagged with the value that produced it.
    typedef struct {
        logic [VALUE_BITS-1:0] tested_value;
        logic                  is_semi;
        logic [SMALL_BITS-1:0] small_f;
        logic [LARGE_BITS-1:0] large_f;
    } factor_result_t;

    logic                  clk;
    logic                  rst_n = 1'b0;
    logic                  start = 1'b0;
    logic [VALUE_BITS-1:0] value = '0;
    logic                  busy;
    logic                  done;
    logic                  semi_flag;
    logic [SMALL_BITS-1:0] small_factor;
    logic [LARGE_BITS-1:0] large_factor;

    // Results predicted for accepted transactions, oldest first.
    factor_result_t pending_factorizations[$];

    int     sender_idle_pct = 7;
    int     failure_count = 0;
    int     sent_count = 0;
    int     semi_seen = 0;
    int     plain_seen = 0;
    longint cycle_count = 0;
    // The watchdog limit grows with every accepted transaction, so a slow but
    // correct run of large values never trips it.
    longint cycle_limit = 5000;

    semiprime_trial_division_core #(
        .VALUE_BITS(VALUE_BITS)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .value(value),
        .busy(busy),
        .done(done),
        .semi_flag(semi_flag),
        .small_factor(small_factor),
        .large_factor(large_factor)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Primality by trial division over 2, 3 and then the 6k-1 / 6k+1 pairs.
    // The loop bound d <= n / d keeps the square of d from overflowing.
    function automatic bit is_prime_num(input longint unsigned n);
        longint unsigned d;
        if (n <= 1)
            return 1'b0;
        if (n <= 3)
            return 1'b1;
        if (n % 2 == 0 || n % 3 == 0)
            return 1'b0;
        for (d = 5; d <= n / d; d += 6)
        begin
            if (n % d == 0 || n % (d + 2) == 0)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // Exact floor of the square root, built one bit at a time from the top.
    function automatic longint unsigned floor_root(input longint unsigned n);
        longint unsigned root;
        longint unsigned trial;
        root = 0;
        for (int b = 31; b >= 0; b--)
        begin
            trial = root | (64'd1 << b);
            if (trial * trial <= n)
                root = trial;
        end
        return root;
    endfunction

    function automatic longint unsigned next_prime(input longint unsigned n);
        longint unsigned c;
        c = n;
        while (!is_prime_num(c))
            c++;
        return c;
    endfunction

    // Expected result for one value. Divisors are scanned upward from 2 to
    // floor(sqrt)+1. The first divisor found is the smallest prime factor;
    // when its cofactor is not prime no later divisor pair can be prime either,
    // so the scan can stop at the first divisor.
    function automatic factor_result_t predict_semiprime(input logic [VALUE_BITS-1:0] v);
        factor_result_t  r;
        longint unsigned n;
        longint unsigned upper;
        n = 64'(v);
        r.tested_value = v;
        r.is_semi = 1'b0;
        r.small_f = '0;
        r.large_f = '0;
        if (n > 3 && !is_prime_num(n))
        begin
            upper = floor_root(n) + 1;
            for (longint unsigned i = 2; i <= upper; i++)
            begin
                if (n % i == 0)
                begin
                    if (is_prime_num(i) && is_prime_num(n / i))
                    begin
                        r.is_semi = 1'b1;
                        // Factors wider than their fields are truncated.
                        r.small_f = i[SMALL_BITS-1:0];
                        r.large_f = LARGE_BITS'(n / i);
                    end
                    break;
                end
            end
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    // Drives one transaction. Random idle cycles come first; they mostly fall
    // while the core is still working on the previous value, so the gaps land
    // on every phase of the division. Start stays high after acceptance so that
    // back-to-back transactions never lower and raise it in the same step.
    task automatic send_value(input logic [VALUE_BITS-1:0] v);
        factor_result_t expected;
        longint unsigned work;
        expected = predict_semiprime(v);
        work = CYCLES_PER_DIVISOR * (floor_root(64'(v)) / 3 + 3);
        while ($urandom_range(99, 0) < sender_idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        value <= v;
        // The edge sees the values from before it, exactly as the core does.
        do
            @(posedge clk);
        while (busy);
        pending_factorizations.push_back(expected);
        cycle_limit += 4 * work + 200;
        sent_count++;
    endtask

    // Random values, weighted so that the run stays short: most values are
    // small or are products of modest primes, and wide values are built with
    // a tiny factor so the core finds their structure within a few divisors.
    function automatic logic [VALUE_BITS-1:0] make_random_value();
        int              kind;
        int              width;
        longint unsigned p;
        longint unsigned q;
        logic [31:0]     word;
        kind = $urandom_range(9, 0);
        word = $urandom();
        if (kind <= 3)
        begin
            width = $urandom_range(16, 2);
            return $urandom_range((1 << width) - 1, 0);
        end
        else if (kind <= 6)
        begin
            p = next_prime($urandom_range(512, 2));
            q = next_prime($urandom_range(65536, 2));
            return VALUE_BITS'(p * q);
        end
        else if (kind == 7)
            return word & 32'hFFFF_FFFC;
        else if (kind == 8)
            return word - (word % 9);
        else
            return VALUE_BITS'(next_prime($urandom_range(1 << 14, 4)));
    endfunction

    task automatic test_tiny_values();
        for (int v = 0; v <= 9; v++)
            send_value(VALUE_BITS'(v));
    endtask

    task automatic test_prime_values();
        logic [VALUE_BITS-1:0] vals [3] = '{97, 65521, 1000003};
        foreach (vals[k])
            send_value(vals[k]);
    endtask

    // Squares of primes, a product of two nearby primes, a large cofactor,
    // and composites with more than two prime factors.
    task automatic test_composite_values();
        logic [VALUE_BITS-1:0] vals [7] = '{15, 49, 63001, 2000006, 1022117, 30, 1024};
        foreach (vals[k])
            send_value(vals[k]);
    endtask

    // Extremes of the input field and wide patterns that toggle every bit.
    task automatic test_wide_values();
        logic [VALUE_BITS-1:0] vals [4] = '{32'hFFFF_FFFF, 32'h8000_0000,
                                            32'h5555_5555, 32'hAAAA_AAAA};
        foreach (vals[k])
            send_value(vals[k]);
    endtask

    task automatic test_random_mix(input int idle_pct, input int count);
        sender_idle_pct = idle_pct;
        repeat (count)
            send_value(make_random_value());
    endtask

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic note_failure(input string msg);
        failure_count++;
        if (failure_count <= FIRST_REPORTS)
            $display("%s", msg);
    endtask

    // A result is valid for exactly one cycle and is taken at the edge that
    // ends it; the receiver has no way to hold it off.
    always @(posedge clk)
    begin : result_check
        factor_result_t head;
        if (rst_n && done)
        begin
            if (pending_factorizations.size() == 0)
                note_failure($sformatf("Unexpected result: semi_flag=%0d small=%0d large=%0d",
                                       semi_flag, small_factor, large_factor));
            else
            begin
                head = pending_factorizations.pop_front();
                if (semi_flag !== head.is_semi || small_factor !== head.small_f ||
                    large_factor !== head.large_f)
                    note_failure($sformatf(
                        "Mismatch for value %0d: expected %0d/%0d/%0d, got %0d/%0d/%0d",
                        head.tested_value, head.is_semi, head.small_f, head.large_f,
                        semi_flag, small_factor, large_factor));
                if (head.is_semi)
                    semi_seen++;
                else
                    plain_seen++;
            end
        end
    end

    // Watchdog on the total cycle count.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > cycle_limit)
        begin
            $display("Timed out after %0d cycles with %0d results outstanding",
                     cycle_count, pending_factorizations.size());
            $display("semiprime_trial_division_core regression: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_tiny_values();
        test_prime_values();
        test_composite_values();
        test_wide_values();

        // Sender idles rarely, then often, then never.
        test_random_mix(7, 25);
        test_random_mix(65, 25);
        test_random_mix(0, 26);

        start <= 1'b0;
        while (pending_factorizations.size() != 0)
            @(posedge clk);
        // Catch any stray strobe after the last expected result.
        repeat (4 * CYCLES_PER_DIVISOR) @(posedge clk);

        $display("Checked %0d transactions (%0d semiprime, %0d not) in %0d cycles,",
                 sent_count, semi_seen, plain_seen, cycle_count);
        $display("covering small values, primes, prime squares and full-width values.");
        if (failure_count == 0)
            $display("semiprime_trial_division_core regression: pass");
        else
            $display("semiprime_trial_division_core regression: fail");
        $finish;
    end

endmodule

// ===== sim.f =====
design/stp_pkg.sv
design/stp_divider.sv
design/stp_cand.sv
design/semiprime_trial_division_core.sv
tb/tb_semiprime_trial_division_core.sv
